// ----- src/cld_pkg.sv -----
package cld_pkg;

	// Sizes
	localparam int MAX_TASKS   = 32;
	localparam int NUM_WINDOWS = 3;
	localparam int NUM_REGS    = 3;
	localparam int CNT_W       = 32;
	localparam int PID_W       = 15;
	localparam int WIN_W       = 2;
	localparam int OP_W        = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int SLOT_W      = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int ACC_W       = CNT_W + SLOT_W;

	// Slot = pid mod MAX_TASKS by reciprocal multiply, exact for all PID_W-bit pids
	localparam int DIV_SH    = PID_W + SLOT_W + 1;
	localparam int DIV_RECIP = ((1 << DIV_SH) + MAX_TASKS - 1) / MAX_TASKS;

	localparam logic [DIV_SH-1:0] DIV_RECIP_P  = DIV_SH'(DIV_RECIP);
	localparam logic [PID_W-1:0]  TASKS_P      = PID_W'(MAX_TASKS);
	localparam logic [SLOT_W:0]   TASK_CNT     = (SLOT_W + 1)'(MAX_TASKS);
	localparam logic [SLOT_W-1:0] LAST_SLOT    = SLOT_W'(MAX_TASKS - 1);
	localparam logic [CNT_W-1:0]  CNT_MAX      = '1;

	// Limit reset values
	localparam logic [CNT_W-1:0] LIMIT_RST [NUM_REGS] = '{
		CNT_W'(200), CNT_W'(1000), CNT_W'(3000)
	};

	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_EXIT  = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_MOD,
		ST_HALVE,
		ST_SUM
	} state_t;

	// One memory row per task slot
	typedef struct packed {
		logic                                valid;
		logic [PID_W-1:0]                    owner;
		logic [NUM_WINDOWS-1:0][CNT_W-1:0]   cnt;
	} row_t;

	// Memory access request
	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		row_t              wdata;
		logic              re;
		logic [SLOT_W-1:0] raddr;
	} mem_req_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + CNT_W'(1);
	endfunction

endpackage

// ----- src/cld_row_ram.sv -----
module cld_row_ram (
	input  logic              clk,
	input  cld_pkg::mem_req_t req,
	output cld_pkg::row_t     rdata
);
	import cld_pkg::*;

	row_t mem_q [MAX_TASKS];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem_q[req.raddr];
		end
	end

endmodule

// ----- src/cpu_load_decay_accounting.sv -----
// Per-task CPU load counters with halving decay. Each task slot (pid modulo
// MAX_TASKS) holds its owner pid, a valid flag and one tick count per window in
// one row of a single-port-read, single-port-write RAM; window totals and limits
// sit in flops. Every transaction reads its slot row; ticks, starts and exits
// write it back. After acceptance come the reciprocal multiply for the slot,
// the slot compute and RAM read, then the row write-back or, for a query, the
// result load. A tick that pushes any window total above its limit adds a
// halving sweep over all rows, which rewrites every row and rebuilds the
// totals of the halved windows; the sweep is paced by one RAM read and one RAM
// write per cycle. A query whose result cannot enter the output register waits
// until it can. After reset a clearing pass over all MAX_TASKS rows zeroes the
// RAM before the first transaction; limit writes are taken throughout.
module cpu_load_decay_accounting (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Input: tdata = pid[14:0], window[16:15], zero pad; tuser = op[1:0]
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [23:0]                           s_tdata,
	input  logic [cld_pkg::OP_W-1:0]              s_tuser,
	// Output: tdata = window_sum[31:0], task_count[63:32]; tuser = status[0]
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [63:0]                           m_tdata,
	output logic [0:0]                            m_tuser,
	// Limit registers
	input  logic                                  cfg_we,
	input  logic [cld_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [cld_pkg::CNT_W-1:0]             cfg_data
);
	import cld_pkg::*;

	state_t state_q, state_d;

	op_t               op_q;
	logic [PID_W-1:0]  pid_q;
	logic [WIN_W-1:0]  win_q;
	logic [PID_W-1:0]  quot_s1;
	logic [SLOT_W-1:0] slot_q;

	logic [CNT_W-1:0]       tot_q   [NUM_WINDOWS];
	logic [CNT_W-1:0]       limit_q [NUM_REGS];
	logic [NUM_WINDOWS-1:0] halve_q;
	logic [SLOT_W:0]        hv_ptr_q;
	logic                   hv_vld_s1;
	logic [SLOT_W-1:0]      hv_addr_s1;
	logic [ACC_W-1:0]       acc_q   [NUM_WINDOWS];
	logic [SLOT_W-1:0]      clr_ptr_q;

	logic             m_tvalid_q;
	logic             status_q;
	logic [CNT_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;

	mem_req_t mem_req;
	row_t     rd_row;

	logic                          accept;
	logic [PID_W+DIV_SH-1:0]       div_prod;
	logic [2*PID_W-1:0]            quot_mul;
	logic [PID_W-1:0]              slot_rem;
	logic [SLOT_W-1:0]             slot_d;
	logic [CNT_W-1:0]              tot_inc [NUM_WINDOWS];
	logic [CNT_W-1:0]              tot_sub [NUM_WINDOWS];
	logic [NUM_WINDOWS-1:0]        over;
	row_t                          tick_row, start_row, exit_row, hv_row;
	logic                          found;
	logic [CNT_W-1:0]              sel_sum, sel_cnt;
	logic                          win_ok;
	logic                          out_free;
	logic                          out_load;

	cld_row_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rd_row)
	);

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// Slot index: quotient by reciprocal, then remainder
	assign div_prod = pid_q * DIV_RECIP_P;
	assign quot_mul = quot_s1 * TASKS_P;
	assign slot_rem = pid_q - quot_mul[PID_W-1:0];
	assign slot_d   = slot_rem[SLOT_W-1:0];

	// Row updates for each operation
	always_comb begin
		tick_row  = rd_row;
		exit_row  = rd_row;
		start_row = rd_row;
		hv_row    = rd_row;
		start_row.owner = pid_q;
		start_row.valid = 1'b1;
		exit_row.valid  = 1'b0;
		for (int w = 0; w < NUM_WINDOWS; w++) begin
			tick_row.cnt[w] = sat_inc(rd_row.cnt[w]);
			exit_row.cnt[w] = '0;
			tot_inc[w]      = sat_inc(tot_q[w]);
			over[w]         = tot_inc[w] > limit_q[w];
			tot_sub[w]      = (tot_q[w] >= rd_row.cnt[w]) ? tot_q[w] - rd_row.cnt[w] : '0;
			if (halve_q[w]) begin
				hv_row.cnt[w] = rd_row.cnt[w] >> 1;
			end
		end
	end

	// Query lookup
	always_comb begin
		win_ok  = 1'b0;
		sel_sum = '0;
		sel_cnt = '0;
		for (int w = 0; w < NUM_WINDOWS; w++) begin
			if (win_q == WIN_W'(w)) begin
				win_ok  = 1'b1;
				sel_sum = tot_q[w];
				sel_cnt = rd_row.cnt[w];
			end
		end
		found = win_ok && rd_row.valid && (rd_row.owner == pid_q);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_ptr_q == LAST_SLOT) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) state_d = ST_DIV;
			end
			ST_DIV:  state_d = ST_READ;
			ST_READ: state_d = ST_MOD;
			ST_MOD: begin
				case (op_q)
					OP_TICK:  state_d = (|over) ? ST_HALVE : ST_IDLE;
					OP_QUERY: state_d = out_free ? ST_IDLE : ST_MOD;
					default:  state_d = ST_IDLE;
				endcase
			end
			ST_HALVE: begin
				if (hv_ptr_q == TASK_CNT && !hv_vld_s1) state_d = ST_SUM;
			end
			ST_SUM:  state_d = ST_IDLE;
			default: state_d = ST_CLEAR;
		endcase
	end

	// State outputs: handshake, memory requests, result load
	always_comb begin
		s_tready = 1'b0;
		out_load = 1'b0;
		mem_req  = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = clr_ptr_q;
			end
			ST_IDLE: s_tready = 1'b1;
			ST_READ: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = slot_d;
			end
			ST_MOD: begin
				mem_req.waddr = slot_q;
				case (op_q)
					OP_TICK: begin
						mem_req.we    = 1'b1;
						mem_req.wdata = tick_row;
					end
					OP_START: begin
						mem_req.we    = 1'b1;
						mem_req.wdata = start_row;
					end
					OP_EXIT: begin
						mem_req.we    = 1'b1;
						mem_req.wdata = exit_row;
					end
					default: out_load = out_free;
				endcase
			end
			ST_HALVE: begin
				mem_req.re    = hv_ptr_q < TASK_CNT;
				mem_req.raddr = hv_ptr_q[SLOT_W-1:0];
				mem_req.we    = hv_vld_s1;
				mem_req.waddr = hv_addr_s1;
				mem_req.wdata = hv_row;
			end
			default: ;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_ptr_q  <= '0;
			hv_ptr_q   <= '0;
			hv_vld_s1  <= 1'b0;
			halve_q    <= '0;
			m_tvalid_q <= 1'b0;
			for (int w = 0; w < NUM_WINDOWS; w++) tot_q[w] <= '0;
			for (int r = 0; r < NUM_REGS; r++) limit_q[r] <= LIMIT_RST[r];
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_ptr_q <= clr_ptr_q + SLOT_W'(1);

			// Limit writes
			if (cfg_we) begin
				for (int r = 0; r < NUM_REGS; r++) begin
					if (cfg_index == CFG_IDX_W'(r)) limit_q[r] <= cfg_data;
				end
			end

			// Totals on tick and exit
			if (state_q == ST_MOD && op_q == OP_TICK) begin
				for (int w = 0; w < NUM_WINDOWS; w++) tot_q[w] <= tot_inc[w];
				halve_q  <= over;
				hv_ptr_q <= '0;
			end
			if (state_q == ST_MOD && op_q == OP_EXIT) begin
				for (int w = 0; w < NUM_WINDOWS; w++) tot_q[w] <= tot_sub[w];
			end

			// Halving sweep
			if (state_q == ST_HALVE) begin
				hv_vld_s1 <= mem_req.re;
				if (mem_req.re) hv_ptr_q <= hv_ptr_q + (SLOT_W + 1)'(1);
			end else begin
				hv_vld_s1 <= 1'b0;
			end
			if (state_q == ST_SUM) begin
				for (int w = 0; w < NUM_WINDOWS; w++) begin
					if (halve_q[w]) begin
						tot_q[w] <= (|acc_q[w][ACC_W-1:CNT_W]) ? CNT_MAX : acc_q[w][CNT_W-1:0];
					end
				end
			end

			// Output register
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_t'(s_tuser);
			pid_q <= s_tdata[PID_W-1:0];
			win_q <= s_tdata[PID_W +: WIN_W];
		end
		if (state_q == ST_DIV) quot_s1 <= div_prod[DIV_SH +: PID_W];
		if (state_q == ST_READ) slot_q <= slot_d;
		if (state_q == ST_MOD && op_q == OP_TICK) begin
			for (int w = 0; w < NUM_WINDOWS; w++) acc_q[w] <= '0;
		end
		if (state_q == ST_HALVE) begin
			hv_addr_s1 <= mem_req.raddr;
			if (hv_vld_s1) begin
				for (int w = 0; w < NUM_WINDOWS; w++) begin
					acc_q[w] <= acc_q[w] + ACC_W'(hv_row.cnt[w]);
				end
			end
		end
		if (out_load) begin
			status_q <= !found;
			sum_q    <= found ? sel_sum : '0;
			cnt_q    <= found ? sel_cnt : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {cnt_q, sum_q};
	assign m_tuser  = status_q;

`ifndef SYNTHESIS
	// Accepted transaction always starts the slot computation
	a_accept_div: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_DIV)
		else $error("accepted transaction did not enter slot computation");

	// Only a query produces a result
	a_result_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(op_q) == OP_QUERY && $past(state_q) == ST_MOD)
		else $error("result produced by a non-query transaction");

	// Not-found results carry zero payload
	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> m_tdata == '0)
		else $error("not-found result with nonzero payload");

	// Sweep pointer stays within the table
	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hv_ptr_q <= TASK_CNT)
		else $error("halving sweep pointer out of range");

	// Sweep never writes the row it reads in the same cycle
	a_sweep_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HALVE && mem_req.we && mem_req.re) |-> mem_req.waddr != mem_req.raddr)
		else $error("halving sweep read and write hit the same row");
`endif

endmodule
